/* design/dap_pkg.sv */
`timescale 1ns / 1ps

package dap_pkg;

    // Field and datapath widths.
    localparam int VAL_W  = 13;   // Q0.12 gains, pan and base volume
    localparam int POS_W  = 16;   // Q8.8 signed coordinates
    localparam int MAG_W  = 17;   // magnitude of a coordinate, up to 32768
    localparam int SUM_W  = 32;   // sum of three squares, below 2^32
    localparam int ROOT_W = 16;   // floor of its square root, Q8.8

    // Gain curve, Q0.12 and Q8.8.
    localparam logic [VAL_W-1:0]  VOL_ONE    = 13'd4096;
    localparam logic [VAL_W-1:0]  VOL_HALF   = 13'd2048;
    localparam logic [VAL_W-1:0]  GAIN_FLOOR = 13'd1434;
    localparam logic [VAL_W-1:0]  GAIN_DROP  = 13'd2662;
    localparam logic [ROOT_W-1:0] DIST_NEAR  = 16'd1536;
    localparam logic [ROOT_W-1:0] DIST_FAR   = 16'd7680;
    localparam logic [VAL_W-1:0]  SPAN_HALF  = 13'd3072;

    // Pan curve.
    localparam logic [VAL_W-1:0]  PAN_CENTRE = 13'd2048;
    localparam logic [MAG_W-1:0]  PAN_SAT_X  = 17'd3073;

    // floor(n / 3) == (n * 2731) >> 13 for every n below 8192.
    localparam logic [VAL_W-1:0]  RECIP3     = 13'd2731;
    localparam int                RECIP3_SH  = 13;

endpackage

/* design/distance_attenuation_pan.sv */
`timescale 1ns / 1ps

// Channel   Direction  Handshake              Word
// --------  ---------  ---------------------  -----------------------------
// input     in         in_valid / in_stall    pos_x, pos_y, pos_z (Q8.8)
// output    out        out_valid / out_stall  volume, pan (Q0.12)
// config    in         cfg_wr_en              cfg_wr_data (base volume)
//
// One word enters per cycle while in_stall is low. Each word passes through the
// pipeline: one stage for magnitudes and pan, one for the squares, one for the
// sum, sixteen for the square root (one root bit per stage), two for the gain
// curve and one for the final multiply into the output register.
// Reset clears every valid bit and sets the base volume to full scale.
// The whole pipeline holds while a finished word waits under out_stall; while
// the output register is empty or being taken, a new word is accepted.

module distance_attenuation_pan
    import dap_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_wr_en,
    input  logic [VAL_W-1:0]        cfg_wr_data,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic signed [POS_W-1:0] pos_x,
    input  logic signed [POS_W-1:0] pos_y,
    input  logic signed [POS_W-1:0] pos_z,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [VAL_W-1:0]        volume,
    output logic [VAL_W-1:0]        pan
);

    // The pipeline moves as one whenever the output register can take a word.
    logic adv;
    assign adv      = !out_valid || !out_stall;
    assign in_stall = !adv;

    // Base volume register; values above full scale saturate.
    logic [VAL_W-1:0] base_volume_reg;
    logic [VAL_W-1:0] base_volume_next;
    assign base_volume_next = (cfg_wr_data > VOL_ONE) ? VOL_ONE : cfg_wr_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_volume_reg <= VOL_ONE;
        end
        else if (cfg_wr_en)
        begin
            base_volume_reg <= base_volume_next;
        end
    end

    // Stage 1: coordinate magnitudes and the complete pan.
    function automatic logic [MAG_W-1:0] mag(input logic [POS_W-1:0] v);
        logic [MAG_W-1:0] e;
        e = {v[POS_W-1], v};
        return v[POS_W-1] ? (~e + MAG_W'(1)) : e;
    endfunction

    logic [MAG_W-1:0]   ax, ay, az;
    logic [VAL_W-1:0]   pan_num;
    logic [2*VAL_W-2:0] pan_prod;
    logic [VAL_W-2:0]   pan_mag;
    logic [VAL_W-1:0]   pan1_next;

    assign ax = mag(pos_x);
    assign ay = mag(pos_y);
    assign az = mag(pos_z);

    // Below the saturation point |x| fits in 12 bits, so 2|x|+1 fits in 13.
    assign pan_num  = {ax[VAL_W-2:0], 1'b1};
    assign pan_prod = (2*VAL_W-1)'(pan_num) * (2*VAL_W-1)'(RECIP3);
    assign pan_mag  = (ax >= PAN_SAT_X) ? VOL_HALF[VAL_W-2:0]
                                        : pan_prod[RECIP3_SH +: VAL_W-1];
    assign pan1_next = pos_x[POS_W-1] ? PAN_CENTRE - {1'b0, pan_mag}
                                      : PAN_CENTRE + {1'b0, pan_mag};

    logic             s1_valid_reg;
    logic [MAG_W-1:0] ax1_reg, ay1_reg, az1_reg;
    logic [VAL_W-1:0] pan1_reg;

    // Stage 2: squares.
    logic             s2_valid_reg;
    logic [SUM_W-1:0] sx2_reg, sy2_reg, sz2_reg;
    logic [2*MAG_W-1:0] sx_full, sy_full, sz_full;
    logic [VAL_W-1:0] pan2_reg;

    assign sx_full = ax1_reg * ax1_reg;
    assign sy_full = ay1_reg * ay1_reg;
    assign sz_full = az1_reg * az1_reg;

    // Stage 3: sum of squares, which stays below 2^32.
    logic             s3_valid_reg;
    logic [SUM_W-1:0] sum3_reg;
    logic [VAL_W-1:0] pan3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ax1_reg  <= ax;
            ay1_reg  <= ay;
            az1_reg  <= az;
            pan1_reg <= pan1_next;
            sx2_reg  <= sx_full[SUM_W-1:0];
            sy2_reg  <= sy_full[SUM_W-1:0];
            sz2_reg  <= sz_full[SUM_W-1:0];
            pan2_reg <= pan1_reg;
            sum3_reg <= sx2_reg + sy2_reg + sz2_reg;
            pan3_reg <= pan2_reg;
        end
    end

    // Distance, carrying the pan alongside.
    logic              root_valid;
    logic [ROOT_W-1:0] root_dist;
    logic [VAL_W-1:0]  root_pan;

    dap_sqrt_pipe u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (s3_valid_reg),
        .sum       (sum3_reg),
        .tag       (pan3_reg),
        .out_valid (root_valid),
        .root      (root_dist),
        .tag_out   (root_pan)
    );

    // Stage 4: region flags and the numerator 2662 * (d - 1536) + 3072.
    // Between the knees d - 1536 is below 6144 and fits in 13 bits.
    localparam int NUM_W = 24;

    logic [ROOT_W-1:0] dist_off;
    logic [NUM_W-1:0]  num4_next;
    assign dist_off  = root_dist - DIST_NEAR;
    assign num4_next = NUM_W'(dist_off[VAL_W-1:0]) * NUM_W'(GAIN_DROP)
                     + NUM_W'(SPAN_HALF);

    logic             s4_valid_reg;
    logic             near4_reg, far4_reg;
    logic [NUM_W-1:0] num4_reg;
    logic [VAL_W-1:0] pan4_reg;

    // Stage 5: divide by 6144 as a shift by 2048 and a reciprocal for 3.
    logic [VAL_W-1:0]   quo_in;
    logic [2*VAL_W-1:0] quo_prod;
    logic [VAL_W-1:0]   gain5_next;
    assign quo_in   = num4_reg[NUM_W-1 -: VAL_W];
    assign quo_prod = (2*VAL_W)'(quo_in) * (2*VAL_W)'(RECIP3);
    assign gain5_next = near4_reg ? VOL_ONE
                      : far4_reg  ? GAIN_FLOOR
                      : VOL_ONE - quo_prod[RECIP3_SH +: VAL_W];

    logic             s5_valid_reg;
    logic [VAL_W-1:0] gain5_reg;
    logic [VAL_W-1:0] pan5_reg;

    // Output stage: base volume times gain, rounded, clamped to full scale.
    logic [2*VAL_W-1:0] vol_prod;
    logic [VAL_W:0]     vol_raw;
    logic [VAL_W-1:0]   vol_next;
    assign vol_prod = (2*VAL_W)'(base_volume_reg) * (2*VAL_W)'(gain5_reg)
                    + (2*VAL_W)'(VOL_HALF);
    assign vol_raw  = vol_prod[2*VAL_W-1 -: VAL_W+1];
    assign vol_next = (vol_raw > (VAL_W+1)'(VOL_ONE)) ? VOL_ONE : vol_raw[VAL_W-1:0];

    logic             out_valid_reg;
    logic [VAL_W-1:0] volume_reg;
    logic [VAL_W-1:0] pan_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_valid_reg  <= 1'b0;
            s5_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s4_valid_reg  <= root_valid;
            s5_valid_reg  <= s4_valid_reg;
            out_valid_reg <= s5_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            near4_reg  <= root_dist <= DIST_NEAR;
            far4_reg   <= root_dist >= DIST_FAR;
            num4_reg   <= num4_next;
            pan4_reg   <= root_pan;
            gain5_reg  <= gain5_next;
            pan5_reg   <= pan4_reg;
            volume_reg <= vol_next;
            pan_reg    <= pan5_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign volume    = volume_reg;
    assign pan       = pan_reg;

    // The distance gain never exceeds one, so a result never beats the base volume.
    a_vol_le_base: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> volume <= base_volume_reg)
        else $error("volume above base volume");

    a_pan_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pan <= VOL_ONE)
        else $error("pan out of range");

    // A held output freezes the inner stages too.
    a_hold_inner: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(s4_valid_reg) && $stable(gain5_reg) && $stable(root_valid))
        else $error("pipeline moved while output held");

endmodule

/* design/dap_sqrt_pipe.sv */
`timescale 1ns / 1ps

// Integer square root, one result bit per register stage, MSB first.
// The remainder form keeps each stage to one compare and one subtract.
module dap_sqrt_pipe
    import dap_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [SUM_W-1:0]  sum,
    input  logic [VAL_W-1:0]  tag,
    output logic              out_valid,
    output logic [ROOT_W-1:0] root,
    output logic [VAL_W-1:0]  tag_out
);

    localparam int TW = SUM_W + 2;

    logic [ROOT_W-1:0] valid_reg;
    logic [SUM_W-1:0]  rem_reg   [ROOT_W];
    logic [ROOT_W-1:0] root_reg  [ROOT_W];
    logic [VAL_W-1:0]  tag_reg   [ROOT_W];

    logic [ROOT_W-1:0] valid_next;
    logic [SUM_W-1:0]  rem_next  [ROOT_W];
    logic [ROOT_W-1:0] root_next [ROOT_W];
    logic [VAL_W-1:0]  tag_next  [ROOT_W];

    for (genvar s = 0; s < ROOT_W; s++) begin : g_stage
        localparam int B = ROOT_W - 1 - s;
        logic              v_in;
        logic [SUM_W-1:0]  rem_in;
        logic [ROOT_W-1:0] root_in;
        logic [VAL_W-1:0]  tag_in;
        logic [TW-1:0]     trial;
        logic              take;

        if (s == 0) begin : g_first
            assign v_in    = in_valid;
            assign rem_in  = sum;
            assign root_in = '0;
            assign tag_in  = tag;
        end
        else begin : g_rest
            assign v_in    = valid_reg[s-1];
            assign rem_in  = rem_reg[s-1];
            assign root_in = root_reg[s-1];
            assign tag_in  = tag_reg[s-1];
        end

        // (root + 2^B)^2 - root^2, with root holding only bits above B.
        assign trial = (TW'(root_in) << (B + 1)) | (TW'(1) << (2 * B));
        assign take  = TW'(rem_in) >= trial;

        assign valid_next[s] = v_in;
        assign rem_next[s]   = take ? rem_in - trial[SUM_W-1:0] : rem_in;
        assign root_next[s]  = take ? root_in | (ROOT_W'(1) << B) : root_in;
        assign tag_next[s]   = tag_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg  <= rem_next;
            root_reg <= root_next;
            tag_reg  <= tag_next;
        end
    end

    assign out_valid = valid_reg[ROOT_W-1];
    assign root      = root_reg[ROOT_W-1];
    assign tag_out   = tag_reg[ROOT_W-1];

endmodule

/* tb/sv/dap_mix_checker.sv */
`timescale 1ns / 1ps

module dap_mix_checker
    import dap_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_wr_en,
    input  logic [VAL_W-1:0]        cfg_wr_data,
    input  logic                    in_valid,
    input  logic                    in_stall,
    input  logic signed [POS_W-1:0] pos_x,
    input  logic signed [POS_W-1:0] pos_y,
    input  logic signed [POS_W-1:0] pos_z,
    input  logic                    out_valid,
    input  logic                    out_stall,
    input  logic [VAL_W-1:0]        volume,
    input  logic [VAL_W-1:0]        pan,
    output int                      errors,
    output int                      pending
);

    typedef struct packed {
        logic [VAL_W-1:0] volume;
        logic [VAL_W-1:0] pan;
    } mix_t;

    mix_t             mix_due[$];
    logic [VAL_W-1:0] base_shadow;
    int               words_out;

    // Bit-serial floor square root.
    function automatic longint unsigned int_root(input longint unsigned sq);
        longint unsigned rem;
        longint unsigned root;
        longint unsigned bitv;
        rem  = sq;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > rem)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (rem >= root + bitv)
            begin
                rem  = rem - (root + bitv);
                root = (root >> 1) + bitv;
            end
            else
            begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    function automatic mix_t attenuate_and_pan(input logic signed [POS_W-1:0] x,
                                               input logic signed [POS_W-1:0] y,
                                               input logic signed [POS_W-1:0] z,
                                               input logic [VAL_W-1:0]        base);
        int              xi;
        int              yi;
        int              zi;
        longint unsigned ax;
        longint unsigned ay;
        longint unsigned az;
        longint unsigned distance;
        longint unsigned gain;
        longint unsigned vol;
        longint unsigned m;
        longint unsigned base_w;
        mix_t            r;
        xi = x;
        yi = y;
        zi = z;
        ax = (xi < 0) ? -xi : xi;
        ay = (yi < 0) ? -yi : yi;
        az = (zi < 0) ? -zi : zi;
        distance = int_root(ax * ax + ay * ay + az * az);

        if (distance <= DIST_NEAR)
            gain = VOL_ONE;
        else if (distance >= DIST_FAR)
            gain = GAIN_FLOOR;
        else
            gain = VOL_ONE - (GAIN_DROP * (distance - DIST_NEAR) + SPAN_HALF)
                             / (2 * SPAN_HALF);

        base_w = base;
        vol = (base_w * gain + VOL_HALF) >> 12;
        if (vol > VOL_ONE)
            vol = VOL_ONE;

        m = (2 * ax + 1) / 3;
        if (m > VOL_HALF)
            m = VOL_HALF;

        r.volume = VAL_W'(vol);
        r.pan    = (xi < 0) ? VAL_W'(PAN_CENTRE - m) : VAL_W'(PAN_CENTRE + m);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        mix_t want;
        int   pushed;
        int   popped;
        if (!rst_n)
        begin
            base_shadow <= VOL_ONE;
            mix_due.delete();
            errors      <= 0;
            pending     <= 0;
            words_out   <= 0;
        end
        else
        begin
            pushed = 0;
            popped = 0;

            // Values above full scale saturate to full scale.
            if (cfg_wr_en)
                base_shadow <= (cfg_wr_data > VOL_ONE) ? VOL_ONE : cfg_wr_data;

            if (out_valid && !out_stall)
            begin
                words_out <= words_out + 1;
                if (mix_due.size() == 0)
                begin
                    if (errors < 10)
                        $display("dap check: word %0d came out with none pending",
                                 words_out);
                    errors <= errors + 1;
                end
                else
                begin
                    want   = mix_due.pop_front();
                    popped = 1;
                    if (volume !== want.volume || pan !== want.pan)
                    begin
                        if (errors < 10)
                            $display({"dap check: word %0d volume exp %0d got %0d,",
                                      " pan exp %0d got %0d"},
                                     words_out, want.volume, volume, want.pan, pan);
                        errors <= errors + 1;
                    end
                end
            end

            if (in_valid && !in_stall)
            begin
                mix_due.push_back(attenuate_and_pan(pos_x, pos_y, pos_z, base_shadow));
                pushed = 1;
            end

            pending <= pending + pushed - popped;
        end
    end

endmodule

/* tb/sv/tb_distance_attenuation_pan.sv */
`timescale 1ns / 1ps

module tb_distance_attenuation_pan;
    import dap_pkg::*;

    // Run shape. The pipeline is 22 stages deep, so a quiet stretch is normal
    // while it fills or drains; the watchdog limit sits far above the longest
    // stall run we expect at a 61 percent idle rate.
    localparam int RESET_CYCLES      = 9;
    localparam int WATCHDOG_LIMIT    = 2000;
    localparam int SETTLE_CYCLES     = 30;
    localparam int SEGMENTS          = 6;
    localparam int WORDS_PER_SEGMENT = 84;

    logic                    clk         = 1'b0;
    logic                    rst_n       = 1'b0;
    logic                    cfg_wr_en   = 1'b0;
    logic [VAL_W-1:0]        cfg_wr_data = '0;
    logic                    in_valid    = 1'b0;
    logic                    in_stall;
    logic signed [POS_W-1:0] pos_x       = '0;
    logic signed [POS_W-1:0] pos_y       = '0;
    logic signed [POS_W-1:0] pos_z       = '0;
    logic                    out_valid;
    logic                    out_stall   = 1'b0;
    logic [VAL_W-1:0]        volume;
    logic [VAL_W-1:0]        pan;

    // Percent chance per cycle that the sender holds back a word and that the
    // receiver stalls the output. The first phase starts with a slow consumer.
    int send_idle = 19;
    int recv_idle = 61;

    int errors;
    int pending;
    int quiet_cycles = 0;

    always #10 clk = ~clk;

    distance_attenuation_pan dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .pos_z       (pos_z),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .volume      (volume),
        .pan         (pan)
    );

    // The checker sits beside the block, sees both channels and the register
    // port, and reports its failure count and the number of words in flight.
    dap_mix_checker mix_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .pos_z       (pos_z),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .volume      (volume),
        .pan         (pan),
        .errors      (errors),
        .pending     (pending)
    );

    // The receiver stalls at random; the rate follows the current phase.
    always @(posedge clk)
        out_stall <= ($urandom_range(99) < recv_idle);

    // Any cycle in which a word moves on either channel restarts the count.
    // A block that hangs or swallows words ends up here.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles + 1 >= WATCHDOG_LIMIT)
        begin
            $display("distance_attenuation_pan verification failed");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Presents one position and returns at the edge where it is taken. The
    // valid is left high afterwards so that back-to-back words need no second
    // assignment in the same step; a drain, or an idle pass in the next call, lowers it.
    task automatic send_word(input logic signed [POS_W-1:0] x,
                             input logic signed [POS_W-1:0] y,
                             input logic signed [POS_W-1:0] z);
        while ($urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        pos_x    <= x;
        pos_y    <= y;
        pos_z    <= z;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // Stops sending and waits until every predicted word has come back. Since
    // every position yields exactly one word, nothing is left in the pipeline
    // once the count reaches zero.
    task automatic drain_pipeline();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    task automatic set_base_volume(input logic [VAL_W-1:0] v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    function automatic logic signed [POS_W-1:0] around(input int span);
        return POS_W'(int'($urandom_range(2 * span)) - span);
    endfunction

    function automatic logic signed [POS_W-1:0] corner_coord();
        case ($urandom_range(4))
            0:       return 16'sh8000;
            1:       return 16'sh7FFF;
            2:       return 16'sh0000;
            3:       return -16'sd1;
            default: return 16'sd1;
        endcase
    endfunction

    // Uniform coordinates almost always land beyond the far distance, so most
    // words are aimed at the full-gain zone, the linear ramp and the pan
    // saturation point, with the rest spread over the whole field or pinned
    // to the corners.
    task automatic random_word();
        int                      kind;
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic signed [POS_W-1:0] z;
        kind = $urandom_range(99);
        if (kind < 30)
        begin
            x = around(1200);
            y = around(1200);
            z = around(1200);
        end
        else if (kind < 60)
        begin
            x = around(5000);
            y = around(5000);
            z = around(5000);
        end
        else if (kind < 75)
        begin
            x = POS_W'($urandom());
            y = POS_W'($urandom());
            z = POS_W'($urandom());
        end
        else if (kind < 90)
        begin
            x = POS_W'($urandom_range(3090, 3060));
            if ($urandom_range(1))
                x = -x;
            y = around(3000);
            z = around(3000);
        end
        else
        begin
            x = corner_coord();
            y = corner_coord();
            z = corner_coord();
        end
        send_word(x, y, z);
    endtask

    initial
    begin
        logic [VAL_W-1:0] bases [SEGMENTS];

        // Base volume per random segment: silence, an over-range write that
        // must saturate, the smallest step, just below full, a random value
        // and full scale again.
        bases[0] = 13'd0;
        bases[1] = 13'd8191;
        bases[2] = 13'd1;
        bases[3] = 13'd4095;
        bases[4] = VAL_W'($urandom_range(8191));
        bases[5] = VOL_ONE;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed words at the reset base volume. The listener's own spot
        // gives full gain and a centered pan.
        send_word(16'sd0, 16'sd0, 16'sd0);
        // The most negative coordinate squares exactly and pans hard left.
        send_word(16'sh8000, 16'sh8000, 16'sh8000);
        send_word(16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
        send_word(16'sh8000, 16'sd0, 16'sd0);
        send_word(16'sh7FFF, 16'sd0, 16'sd0);
        send_word(16'sd0, 16'sh8000, 16'sd0);
        send_word(16'sd0, 16'sd0, 16'sh8000);
        // Both ends of the linear part of the gain curve.
        send_word(16'sd1536, 16'sd0, 16'sd0);
        send_word(16'sd1537, 16'sd0, 16'sd0);
        send_word(16'sd0, 16'sd0, 16'sd1535);
        send_word(16'sd0, 16'sd7679, 16'sd0);
        send_word(16'sd0, 16'sd7680, 16'sd0);
        send_word(16'sd0, -16'sd4608, 16'sd0);
        send_word(16'sd1000, 16'sd2000, -16'sd3000);
        // Pan steps near the center and around the saturation point.
        send_word(16'sd1, 16'sd0, 16'sd0);
        send_word(-16'sd1, 16'sd0, 16'sd0);
        send_word(16'sd2, 16'sd0, 16'sd0);
        send_word(16'sd3071, 16'sd0, 16'sd0);
        send_word(16'sd3072, 16'sd0, 16'sd0);
        send_word(16'sd3073, 16'sd0, 16'sd0);
        send_word(-16'sd3072, 16'sd0, 16'sd0);
        send_word(-16'sd3073, 16'sd0, 16'sd0);

        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            // The register only changes with the pipeline empty, and each
            // drain also pauses the sender until every word has returned.
            drain_pipeline();
            set_base_volume(bases[seg]);
            if (seg == 2)
            begin
                send_idle = 61;
                recv_idle <= 19;
            end
            else if (seg == 4)
            begin
                send_idle = 0;
                recv_idle <= 0;
            end
            repeat (WORDS_PER_SEGMENT) random_word();
        end

        drain_pipeline();
        repeat (SETTLE_CYCLES) @(posedge clk);

        // Any word still pending here never came out of the block.
        if (errors == 0 && pending == 0)
            $display("distance_attenuation_pan verification clean");
        else
            $display("distance_attenuation_pan verification failed");
        $finish;
    end

endmodule
